// ----- src/assert_macros.svh -----
// Assertion macros used by sha256_block_compress_top.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

`define ASSERT_NOT_BOTH(lbl, clk, rstn, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !((a) && (b))) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rstn, prop, msg)

`define ASSERT_NOT_BOTH(lbl, clk, rstn, a, b, msg)

`endif

`endif

// ----- src/sha256bc_pkg.sv -----
package sha256bc_pkg;

  localparam int unsigned NumRounds   = 64;
  localparam int unsigned DigestWords = 8;
  localparam int unsigned BlockWords  = 16;
  localparam int unsigned CountW      = $clog2(BlockWords);
  localparam int unsigned RoundW      = $clog2(NumRounds);
  localparam int unsigned IdxW        = $clog2(DigestWords);

  typedef logic [31:0] word_t;

  typedef enum logic [3:0] {
    StCollect = 4'b0001,
    StRound   = 4'b0010,
    StAdd     = 4'b0100,
    StEmit    = 4'b1000
  } state_e;

  localparam word_t RoundConst [NumRounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam word_t InitHash [DigestWords] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic word_t ror(input word_t v, input int unsigned s);
    return (v >> s) | (v << (32 - s));
  endfunction

  function automatic word_t ssig0(input word_t x);
    return ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t ssig1(input word_t x);
    return ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t bsig0(input word_t x);
    return ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
  endfunction

  function automatic word_t bsig1(input word_t x);
    return ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
  endfunction

endpackage

// ----- src/sha256bc_in_if.sv -----
interface sha256bc_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] msg_word;
  logic        new_message;

  modport source (output valid, output msg_word, output new_message, input ready);
  modport sink (input valid, input msg_word, input new_message, output ready);
endinterface

// ----- src/sha256bc_out_if.sv -----
interface sha256bc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index, output last_word,
                  input ready);
  modport sink (input valid, input digest_word, input word_index, input last_word,
                output ready);
endinterface

// ----- src/sha256_block_compress_top.sv -----
// Takes one message word per cycle while collecting a block of sixteen.
// The first digest beat is offered after the sixteenth word is taken, once the block
// has run through the 64 rounds on the single shared round unit and the final add.
// A block goes through collecting 16 words, the rounds, the add and 8 digest beats out.
// Reset clears the sequencer and loads the chaining value with the initial hash.
`include "assert_macros.svh"

module sha256_block_compress_top (
  input  logic clk_i,
  input  logic rst_ni,
  sha256bc_in_if.sink    msg_i,
  sha256bc_out_if.source dig_o
);
  import sha256bc_pkg::*;

  state_e              state_q, state_d;
  logic [CountW-1:0]   cnt_q, cnt_d;
  logic [RoundW-1:0]   rnd_q, rnd_d;
  logic [IdxW-1:0]     idx_q, idx_d;
  word_t               chain_q [DigestWords];
  word_t               chain_d [DigestWords];
  word_t               win_q [BlockWords];
  word_t               win_d [BlockWords];
  word_t               v_q [DigestWords];
  word_t               v_d [DigestWords];

  logic              in_fire, out_fire;
  logic [CountW-1:0] cnt_base;
  word_t             sched_new, t1, t2, choose, major;

  assign in_fire  = msg_i.valid && msg_i.ready;
  assign out_fire = dig_o.valid && dig_o.ready;

  assign sched_new = win_q[0] + ssig0(win_q[1]) + win_q[9] + ssig1(win_q[14]);
  assign choose    = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
  assign major     = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
  assign t1        = v_q[7] + bsig1(v_q[4]) + choose + RoundConst[rnd_q] + win_q[0];
  assign t2        = bsig0(v_q[0]) + major;
  assign cnt_base  = msg_i.new_message ? '0 : cnt_q;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    rnd_d   = rnd_q;
    idx_d   = idx_q;
    chain_d = chain_q;
    win_d   = win_q;
    v_d     = v_q;
    unique case (state_q)
      StCollect: begin
        if (in_fire) begin
          if (msg_i.new_message) begin
            chain_d = InitHash;
          end
          for (int i = 0; i < BlockWords - 1; i++) begin
            win_d[i] = win_q[i+1];
          end
          win_d[BlockWords-1] = msg_i.msg_word;
          cnt_d = cnt_base + CountW'(1);
          if (cnt_base == CountW'(BlockWords - 1)) begin
            state_d = StRound;
            rnd_d   = '0;
            v_d     = chain_q;
          end
        end
      end
      StRound: begin
        for (int i = 0; i < BlockWords - 1; i++) begin
          win_d[i] = win_q[i+1];
        end
        win_d[BlockWords-1] = sched_new;
        v_d[7] = v_q[6];
        v_d[6] = v_q[5];
        v_d[5] = v_q[4];
        v_d[4] = v_q[3] + t1;
        v_d[3] = v_q[2];
        v_d[2] = v_q[1];
        v_d[1] = v_q[0];
        v_d[0] = t1 + t2;
        rnd_d  = rnd_q + RoundW'(1);
        if (rnd_q == RoundW'(NumRounds - 1)) begin
          state_d = StAdd;
        end
      end
      StAdd: begin
        for (int i = 0; i < DigestWords; i++) begin
          chain_d[i] = chain_q[i] + v_q[i];
        end
        idx_d   = '0;
        state_d = StEmit;
      end
      StEmit: begin
        if (out_fire) begin
          idx_d = idx_q + IdxW'(1);
          if (idx_q == IdxW'(DigestWords - 1)) begin
            state_d = StCollect;
          end
        end
      end
      default: begin
        state_d = StCollect;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StCollect;
      cnt_q   <= '0;
      rnd_q   <= '0;
      idx_q   <= '0;
      chain_q <= InitHash;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      rnd_q   <= rnd_d;
      idx_q   <= idx_d;
      chain_q <= chain_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
    v_q   <= v_d;
  end

  assign msg_i.ready       = (state_q == StCollect);
  assign dig_o.valid       = (state_q == StEmit);
  assign dig_o.digest_word = chain_q[idx_q];
  assign dig_o.word_index  = idx_q;
  assign dig_o.last_word   = (idx_q == IdxW'(DigestWords - 1));

  `ASSERT_NOT_BOTH(a_no_in_while_out, clk_i, rst_ni, msg_i.ready, dig_o.valid, "input open while digest beats are pending")
  `ASSERT_PROP(a_rounds_end, clk_i, rst_ni, (state_q == StRound && rnd_q == RoundW'(NumRounds - 1)) |=> (state_q == StAdd), "round loop did not end after the last round")
  `ASSERT_PROP(a_emit_starts_at_zero, clk_i, rst_ni, $rose(dig_o.valid) |-> (dig_o.word_index == '0), "digest beats do not start with the first word")
  `ASSERT_PROP(a_ready_after_last, clk_i, rst_ni, (out_fire && dig_o.last_word) |=> msg_i.ready, "input not reopened after the last digest beat")

endmodule

// ----- tb/sha256bc_tb_pkg.sv -----
package sha256bc_tb_pkg;

  import sha256bc_pkg::*;

  typedef struct packed {
    word_t      digest;
    logic [2:0] pos;
    logic       last;
  } digest_beat_t;

  class digest_scoreboard;
    word_t        chain[DigestWords];
    word_t        held[BlockWords];
    int unsigned  fill;
    digest_beat_t expected_q[$];
    int unsigned  failures;
    int unsigned  beats_seen;

    function new();
      reload_chain();
      fill       = 0;
      failures   = 0;
      beats_seen = 0;
    endfunction

    function void reload_chain();
      foreach (chain[i]) chain[i] = InitHash[i];
    endfunction

    function word_t rot_right(word_t x, int unsigned n);
      return (x >> n) | (x << (32 - n));
    endfunction

    function void compress();
      word_t sched[NumRounds];
      word_t va, vb, vc, vd, ve, vf, vg, vh;
      word_t lo_sig, hi_sig, t1, t2;
      for (int i = 0; i < BlockWords; i++) sched[i] = held[i];
      for (int i = BlockWords; i < NumRounds; i++) begin
        lo_sig = rot_right(sched[i-15], 7) ^ rot_right(sched[i-15], 18) ^ (sched[i-15] >> 3);
        hi_sig = rot_right(sched[i-2], 17) ^ rot_right(sched[i-2], 19) ^ (sched[i-2] >> 10);
        sched[i] = sched[i-16] + lo_sig + sched[i-7] + hi_sig;
      end
      va = chain[0]; vb = chain[1]; vc = chain[2]; vd = chain[3];
      ve = chain[4]; vf = chain[5]; vg = chain[6]; vh = chain[7];
      for (int i = 0; i < NumRounds; i++) begin
        t1 = vh + (rot_right(ve, 6) ^ rot_right(ve, 11) ^ rot_right(ve, 25))
             + ((ve & vf) ^ (~ve & vg)) + RoundConst[i] + sched[i];
        t2 = (rot_right(va, 2) ^ rot_right(va, 13) ^ rot_right(va, 22))
             + ((va & vb) ^ (va & vc) ^ (vb & vc));
        vh = vg; vg = vf; vf = ve; ve = vd + t1;
        vd = vc; vc = vb; vb = va; va = t1 + t2;
      end
      chain[0] += va; chain[1] += vb; chain[2] += vc; chain[3] += vd;
      chain[4] += ve; chain[5] += vf; chain[6] += vg; chain[7] += vh;
    endfunction

    function void note_word(word_t w, logic restart);
      digest_beat_t beat;
      if (restart) begin
        reload_chain();
        fill = 0;
      end
      held[fill] = w;
      fill = (fill + 1) % BlockWords;
      if (fill == 0) begin
        compress();
        for (int i = 0; i < DigestWords; i++) begin
          beat.digest = chain[i];
          beat.pos    = 3'(i);
          beat.last   = (i == DigestWords - 1);
          expected_q.push_back(beat);
        end
      end
    endfunction

    function void check_beat(word_t digest, logic [2:0] pos, logic last);
      digest_beat_t want;
      beats_seen++;
      if (expected_q.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected digest beat: %h pos %0d last %b", digest, pos, last);
        return;
      end
      want = expected_q.pop_front();
      if (want.digest !== digest || want.pos !== pos || want.last !== last) begin
        failures++;
        if (failures <= 10)
          $display("digest beat %0d: expected %h pos %0d last %b, got %h pos %0d last %b",
                   beats_seen, want.digest, want.pos, want.last, digest, pos, last);
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

endpackage

// ----- tb/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sha256bc_pkg::*;
  import sha256bc_tb_pkg::*;

  localparam int unsigned StallLimit = 3000;
  localparam int unsigned WordTarget = 310;

  logic clk_i;
  logic rst_ni;
  int unsigned words_sent;
  int unsigned quiet_cycles;
  logic sender_steady;

  digest_scoreboard sb = new();

  sha256bc_in_if  msg_if ();
  sha256bc_out_if dig_if ();

  sha256_block_compress_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .msg_i  (msg_if),
    .dig_o  (dig_if)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Each call starts and ends at a falling edge; valid is left high so that
  // back-to-back words need no second assignment in the same step.
  task automatic send_word(input word_t w, input logic restart);
    while (!sender_steady && $urandom_range(99) < 26) begin
      msg_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    msg_if.valid       <= 1'b1;
    msg_if.msg_word    <= w;
    msg_if.new_message <= restart;
    do @(posedge clk_i); while (!msg_if.ready);
    sb.note_word(w, restart);
    words_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_block(input int unsigned len, input logic restart);
    word_t w;
    int unsigned pick;
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(99);
      if (pick < 8) w = '0;
      else if (pick < 16) w = '1;
      else w = $urandom();
      send_word(w, restart && (i == 0));
    end
  endtask

  task automatic drain_results();
    msg_if.valid <= 1'b0;
    do @(negedge clk_i); while (sb.pending() != 0);
  endtask

  initial begin
    int unsigned kind;
    logic pause_done;
    rst_ni             = 1'b0;
    msg_if.valid       = 1'b0;
    msg_if.msg_word    = '0;
    msg_if.new_message = 1'b0;
    sender_steady      = 1'b0;
    words_sent         = 0;
    pause_done         = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // The first block after reset carries no flag and so chains from the initial hash.
    for (int i = 0; i < BlockWords; i++)
      send_word((i % 2 == 0) ? 32'h0000_0000 : 32'hffff_ffff, 1'b0);
    // A flag on a fresh block, then a flag in mid-block that drops the partial block.
    send_word(32'h8000_0000, 1'b1);
    send_word(32'h0000_0001, 1'b0);
    send_word(32'hffff_ffff, 1'b0);
    send_word(32'h7fff_ffff, 1'b0);
    send_word(32'h6162_6380, 1'b1);

    while (words_sent < WordTarget) begin
      sender_steady = (words_sent >= 140 && words_sent < 210);
      if (!pause_done && words_sent >= 100) begin
        drain_results();
        pause_done = 1'b1;
      end
      kind = $urandom_range(99);
      if (kind < 80) send_block(BlockWords, $urandom_range(99) < 40);
      else if (kind < 90) begin
        send_block($urandom_range(1, BlockWords - 1), 1'($urandom_range(1)));
        send_block(BlockWords, 1'b1);
      end else
        send_word($urandom(), 1'($urandom_range(1)));
    end
    msg_if.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (sb.failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    dig_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (sb.beats_seen >= 60 && sb.beats_seen < 110) begin
        dig_if.ready <= 1'b1;
      end else begin
        dig_if.ready <= ($urandom_range(99) >= 26);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && dig_if.valid && dig_if.ready) begin
      sb.check_beat(dig_if.digest_word, dig_if.word_index, dig_if.last_word);
    end
  end

  initial quiet_cycles = 0;

  always @(posedge clk_i) begin
    if ((msg_if.valid && msg_if.ready) || (dig_if.valid && dig_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

endmodule
